// ===== design/clad_pkg.sv =====
// Package for the chain line dasher: field widths, register indexes,
// reset values of the length registers and default parameter values.
// No dependencies.
package clad_pkg;

  // Fraction bits of all coordinates and lengths
  localparam int COORD_FRAC_BITS = 10;
  // Default for the piece limit of the top level
  localparam int MAX_PIECES_DEF  = 64;

  // Port widths
  localparam int VIEW_W = 22;
  localparam int SHEET_OUT_W = 24;
  localparam int LEN_W = 16;
  localparam int SCALE_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DASH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRUN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFY    = 3'd6;

  // Clamp a reset length to the 16-bit register range
  function automatic logic [LEN_W-1:0] sat16(input longint v);
    logic [LEN_W-1:0] r;
    r = (v > 65535) ? 16'hFFFF : v[LEN_W-1:0];
    return r;
  endfunction

  localparam logic [LEN_W-1:0] DASH_RST    = sat16(longint'(6) << COORD_FRAC_BITS);
  localparam logic [LEN_W-1:0] GAP_RST     = sat16((longint'(3) << COORD_FRAC_BITS) / 4);
  localparam logic [LEN_W-1:0] DOT_RST     = sat16((longint'(1) << COORD_FRAC_BITS) / 4);
  localparam logic [LEN_W-1:0] OVERRUN_RST = sat16(longint'(3) << COORD_FRAC_BITS);
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;

endpackage

// ===== design/chain_line_dasher.sv =====
// Chain line dasher top level: maps two view centres to the sheet and
// emits the dash-gap-dot-gap pieces of the extended centre line.
// Depends on clad_pkg.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. Busy
//   stays high until the last piece of that item has gone out. Each piece
//   appears for one cycle with result_strobe high; last_piece marks the
//   final piece, truncated is set on it when further pieces were dropped.
//   An item with a missing centre gives no piece and never raises busy;
//   coincident centres give no piece after the centre mapping and the
//   difference.
//   Steps: the centres are mapped, the difference is taken, the squares are
//   summed and the root is drawn; then per piece come a setup step, four
//   endpoint divisions (multiply, load, quotient steps, store) and an output
//   step.
//   The products share one multiplier and the root and quotient steps one
//   36-bit subtractor under the sequencer; the bit-serial division sets the
//   piece rate.
//   The receiver cannot stall: results are never held back.
//   Configuration writes land at once and are to be made while busy is low.
//   Reset (rst, synchronous) returns to idle and loads the default lengths,
//   unit scale and zero offsets.
module chain_line_dasher
  #(parameter int MAX_PIECES = clad_pkg::MAX_PIECES_DEF)
  (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic wr_en,
  input  logic [clad_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [clad_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic first_present,
  input  logic second_present,
  input  logic signed [clad_pkg::VIEW_W-1:0] first_x,
  input  logic signed [clad_pkg::VIEW_W-1:0] first_y,
  input  logic signed [clad_pkg::VIEW_W-1:0] second_x,
  input  logic signed [clad_pkg::VIEW_W-1:0] second_y,
  output logic result_strobe,
  output logic signed [clad_pkg::SHEET_OUT_W-1:0] start_x,
  output logic signed [clad_pkg::SHEET_OUT_W-1:0] start_y,
  output logic signed [clad_pkg::SHEET_OUT_W-1:0] end_x,
  output logic signed [clad_pkg::SHEET_OUT_W-1:0] end_y,
  output logic is_dot,
  output logic last_piece,
  output logic truncated
  );
  import clad_pkg::*;

  localparam int NW = $clog2(MAX_PIECES) + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MAP_MUL  = 4'd1;
  localparam logic [3:0] S_MAP_ACC  = 4'd2;
  localparam logic [3:0] S_DIFF     = 4'd3;
  localparam logic [3:0] S_SQ_MUL   = 4'd4;
  localparam logic [3:0] S_SQ_ACC   = 4'd5;
  localparam logic [3:0] S_SQRT     = 4'd6;
  localparam logic [3:0] S_SETUP    = 4'd7;
  localparam logic [3:0] S_PT_MUL   = 4'd8;
  localparam logic [3:0] S_PT_LOAD  = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_PT_STORE = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  localparam logic signed [34:0] OUT_HI = 35'sd8388607;
  localparam logic signed [34:0] OUT_LO = -35'sd8388608;

  // Configuration registers
  logic [LEN_W-1:0] dash_len, gap_len, dot_len, ov_len;
  logic [SCALE_W-1:0] scale;
  logic signed [VIEW_W-1:0] off_x, off_y;

  logic [3:0] state;
  logic [1:0] idx;
  logic [5:0] iter;

  // Latched item
  logic signed [VIEW_W-1:0] vx0, vy0, vx1, vy1;
  // Sheet centres, differences and lengths
  logic signed [30:0] ax, ay, bx, by;
  logic signed [31:0] dx, dy;
  logic [63:0] sq_sum;
  logic [33:0] srem;
  logic [31:0] root;
  logic [30:0] len;
  logic [33:0] total, cursor;
  logic kind;
  logic [NW-1:0] n;
  logic signed [33:0] s0, s1;
  // Multiplier and division registers
  logic signed [67:0] prod;
  logic [30:0] drem;
  logic [32:0] qsh;
  logic qneg;

  // Shared multiplier and subtractor
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic [35:0] sub_a, sub_b;
  logic [36:0] sub_d;
  logic borrow;

  // Piece geometry
  logic [17:0] cyc;
  logic [33:0] dash_end, dot_start, dot_end, pfrom, pto_raw, pto, cur_next;
  logic dot_ok, more_ok, next_exists, at_limit;
  logic [NW-1:0] n_plus;

  // Map and division helpers
  logic signed [VIEW_W-1:0] view_sel, off_sel;
  logic signed [67:0] rnd;
  logic signed [30:0] sheet_val;
  logic signed [31:0] dxc, dyc;
  logic signed [67:0] pabs;
  logic [63:0] numr;
  logic [31:0] dt;
  logic signed [34:0] qv, csum;
  logic signed [30:0] base;
  logic signed [SHEET_OUT_W-1:0] coord;

  assign busy = (state != S_IDLE);

  // Piece bounds and lookahead for the next piece
  always_comb begin
    cyc       = 18'(dash_len) + 18'(gap_len) + 18'(gap_len) + 18'(dot_len);
    dash_end  = cursor + 34'(dash_len);
    dot_start = dash_end + 34'(gap_len);
    dot_end   = dot_start + 34'(dot_len);
    cur_next  = cursor + 34'(cyc);
    pfrom     = kind ? dot_start : cursor;
    pto_raw   = kind ? dot_end : dash_end;
    pto       = (pto_raw > total) ? total : pto_raw;
    dot_ok    = (dot_start < total);
    more_ok   = (cur_next < total);
    next_exists = (!kind && dot_ok) || more_ok;
    n_plus    = n + NW'(1);
    at_limit  = (n_plus >= NW'(MAX_PIECES));
  end

  // Select operands of the shared multiplier
  always_comb begin
    unique case (idx)
      2'd0: begin view_sel = vx0; off_sel = off_x; end
      2'd1: begin view_sel = vy0; off_sel = off_y; end
      2'd2: begin view_sel = vx1; off_sel = off_x; end
      default: begin view_sel = vy1; off_sel = off_y; end
    endcase
    mul_a = 34'(dx);
    mul_b = 34'(dx);
    unique case (state)
      S_MAP_MUL: begin
        mul_a = 34'(view_sel);
        mul_b = $signed({10'b0, scale});
      end
      S_SQ_MUL: begin
        mul_a = idx[0] ? 34'(dy) : 34'(dx);
        mul_b = idx[0] ? 34'(dy) : 34'(dx);
      end
      S_PT_MUL: begin
        mul_a = idx[0] ? 34'(dy) : 34'(dx);
        mul_b = idx[1] ? s1 : s0;
      end
      default: begin
        mul_a = 34'(dx);
        mul_b = 34'(dx);
      end
    endcase
    mul_p = 68'(mul_a) * 68'(mul_b);
  end

  // Select operands of the shared subtractor: root step or quotient step
  always_comb begin
    dt = {drem, qsh[32]};
    if (state == S_SQRT) begin
      sub_a = {srem, sq_sum[63:62]};
      sub_b = {2'b0, root, 2'b01};
    end else begin
      sub_a = {4'b0, dt};
      sub_b = {5'b0, len};
    end
    sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    borrow = sub_d[36];
  end

  // Scale rounding, differences, division operands and endpoint saturation
  always_comb begin
    rnd = prod + 68'sd32768;
    sheet_val = 31'(rnd >>> 16) + 31'(off_sel);
    dxc = 32'(bx) - 32'(ax);
    dyc = 32'(by) - 32'(ay);
    pabs = prod[67] ? -prod : prod;
    numr = pabs[63:0] + 64'(len[30:1]);
    qv = qneg ? -$signed({2'b0, qsh}) : $signed({2'b0, qsh});
    base = idx[0] ? ay : ax;
    csum = 35'(base) + qv;
    if (csum > OUT_HI) begin
      coord = OUT_HI[SHEET_OUT_W-1:0];
    end else if (csum < OUT_LO) begin
      coord = OUT_LO[SHEET_OUT_W-1:0];
    end else begin
      coord = csum[SHEET_OUT_W-1:0];
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dash_len <= DASH_RST;
      gap_len  <= GAP_RST;
      dot_len  <= DOT_RST;
      ov_len   <= OVERRUN_RST;
      scale    <= SCALE_RST;
      off_x    <= '0;
      off_y    <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DASH:    dash_len <= wr_data[LEN_W-1:0];
        REG_GAP:     gap_len  <= wr_data[LEN_W-1:0];
        REG_DOT:     dot_len  <= wr_data[LEN_W-1:0];
        REG_OVERRUN: ov_len   <= wr_data[LEN_W-1:0];
        REG_SCALE:   scale    <= wr_data[SCALE_W-1:0];
        REG_OFFX:    off_x    <= $signed(wr_data[VIEW_W-1:0]);
        REG_OFFY:    off_y    <= $signed(wr_data[VIEW_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      iter  <= '0;
      kind  <= 1'b0;
      n     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && first_present && second_present) begin
            state <= S_MAP_MUL;
            idx   <= '0;
          end
        end
        S_MAP_MUL: state <= S_MAP_ACC;
        S_MAP_ACC: begin
          idx   <= idx + 2'd1;
          state <= (idx == 2'd3) ? S_DIFF : S_MAP_MUL;
        end
        S_DIFF: begin
          idx   <= '0;
          state <= (dxc == '0 && dyc == '0) ? S_IDLE : S_SQ_MUL;
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          idx  <= idx + 2'd1;
          iter <= '0;
          state <= idx[0] ? S_SQRT : S_SQ_MUL;
        end
        S_SQRT: begin
          iter <= iter + 6'd1;
          if (iter == 6'd31) begin
            state <= S_SETUP;
            kind  <= 1'b0;
            n     <= '0;
          end
        end
        S_SETUP: begin
          idx   <= '0;
          state <= S_PT_MUL;
        end
        S_PT_MUL: state <= S_PT_LOAD;
        S_PT_LOAD: begin
          iter  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          iter <= iter + 6'd1;
          if (iter == 6'd32) begin
            state <= S_PT_STORE;
          end
        end
        S_PT_STORE: begin
          idx   <= idx + 2'd1;
          state <= (idx == 2'd3) ? S_EMIT : S_PT_MUL;
        end
        S_EMIT: begin
          if (!next_exists || at_limit) begin
            state <= S_IDLE;
          end else begin
            n     <= n_plus;
            kind  <= !kind && dot_ok;
            state <= S_SETUP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        vx0 <= first_x;
        vy0 <= first_y;
        vx1 <= second_x;
        vy1 <= second_y;
      end
      S_MAP_MUL, S_SQ_MUL, S_PT_MUL: prod <= mul_p;
      S_MAP_ACC: begin
        case (idx)
          2'd0: ax <= sheet_val;
          2'd1: ay <= sheet_val;
          2'd2: bx <= sheet_val;
          default: by <= sheet_val;
        endcase
      end
      S_DIFF: begin
        dx     <= dxc;
        dy     <= dyc;
        sq_sum <= '0;
      end
      S_SQ_ACC: begin
        sq_sum <= sq_sum + prod[63:0];
        srem   <= '0;
        root   <= '0;
      end
      S_SQRT: begin
        // one root digit per cycle, two radicand bits consumed
        srem   <= borrow ? sub_a[33:0] : sub_d[33:0];
        root   <= {root[30:0], !borrow};
        sq_sum <= {sq_sum[61:0], 2'b00};
        if (iter == 6'd31) begin
          len    <= {root[29:0], !borrow};
          total  <= 34'({root[29:0], !borrow}) + 34'(ov_len) + 34'(ov_len);
          cursor <= '0;
        end
      end
      S_SETUP: begin
        s0 <= $signed(pfrom) - $signed(34'(ov_len));
        s1 <= $signed(pto) - $signed(34'(ov_len));
      end
      S_PT_LOAD: begin
        qneg <= prod[67];
        drem <= numr[63:33];
        qsh  <= numr[32:0];
      end
      S_DIV: begin
        // one quotient bit per cycle
        drem <= borrow ? dt[30:0] : sub_d[30:0];
        qsh  <= {qsh[31:0], !borrow};
      end
      S_PT_STORE: begin
        case (idx)
          2'd0: start_x <= coord;
          2'd1: start_y <= coord;
          2'd2: end_x <= coord;
          default: end_y <= coord;
        endcase
      end
      S_EMIT: begin
        if (!kind && !dot_ok) begin
          cursor <= cur_next;
        end else if (kind) begin
          cursor <= cur_next;
        end
      end
      default: ;
    endcase
  end

  // Drive the result strobe and piece flags
  assign result_strobe = (state == S_EMIT);
  assign is_dot        = kind;
  assign last_piece    = result_strobe && (!next_exists || at_limit);
  assign truncated     = result_strobe && next_exists && at_limit;

endmodule
